>>> rtl/lbf_pkg.sv
// Shared types and constants for the LED brightness fade ramp.
package lbf_pkg;

    localparam int TIMER_BITS = 26;
    localparam int MS_BITS    = 16;
    localparam int CFG_BITS   = 8;
    localparam int FUNC_BITS  = 3;
    localparam int OUT_BITS   = 16;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [9:0]            US_PER_MS = 10'd1000;
    localparam logic [CFG_BITS-1:0]   MAX_RESET = 8'd255;

    // One quotient bit per divider step.
    localparam int DIV_STEPS = TIMER_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);
    localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(DIV_STEPS - 1);

    localparam logic [FUNC_BITS-1:0] FUNC_TICK     = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_HARD_OFF = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_HARD_ON  = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_SOFT_ON  = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_SOFT_OFF = 3'd4;

    typedef struct packed {
        logic capture;
        logic do_tick;
        logic do_off;
        logic do_on;
        logic fade_start;
        logic div_step;
        logic load_out;
    } lbf_cmd_t;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic                 top_zero;
        logic                 div_last;
    } lbf_status_t;

endpackage

>>> rtl/led_brightness_fade_ramp.sv
// LED brightness fade ramp: top level joining sequencer and datapath.
// Tick, hard on/off and unused codes: a command is captured in idle, executed, then loaded into the
// output register in the response state. Soft on/off with a nonzero max first runs the 26-step
// serial divider computing 1000 * ms / max; a zero max skips it. One command is handled at a time.
// The next command is accepted while a finished result still waits on the output.
// Reset (aresetn low, synchronous) clears level, interval, elapsed count, direction and output valid.
module led_brightness_fade_ramp import lbf_pkg::*; #(
    parameter int LEVEL_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_BITS-1:0]  cfg_wdata,   // max_brightness
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [MS_BITS-1:0]   s_tdata,     // [15:0] fade_ms
    input  logic [FUNC_BITS-1:0] s_tuser,     // [2:0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_BITS-1:0]  m_tdata      // [7:0] brightness, [8] fading, [15:9] zero
);

    lbf_cmd_t    cmd;
    lbf_status_t status;

    lbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lbf_datapath #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_func    (s_tuser),
        .s_fade_ms (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule

>>> rtl/lbf_ctrl.sv
// Command sequencer and stream handshake for the fade ramp.
module lbf_ctrl import lbf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  lbf_status_t status,
    output lbf_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESP;
                case (status.func)
                    FUNC_TICK:     cmd.do_tick = 1'b1;
                    FUNC_HARD_OFF: cmd.do_off  = 1'b1;
                    FUNC_HARD_ON:  cmd.do_on   = 1'b1;
                    FUNC_SOFT_ON, FUNC_SOFT_OFF: begin
                        cmd.fade_start = 1'b1;
                        if (!status.top_zero) begin
                            state_next = ST_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                // Load the result once the output register is free or draining.
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> rtl/lbf_datapath.sv
// Fade state registers, serial interval divider and result register.
module lbf_datapath import lbf_pkg::*; #(
    parameter int LEVEL_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_BITS-1:0]  cfg_wdata,
    input  logic [FUNC_BITS-1:0] s_func,
    input  logic [MS_BITS-1:0]   s_fade_ms,
    input  lbf_cmd_t             cmd,
    output lbf_status_t          status,
    output logic [OUT_BITS-1:0]  m_tdata
);

    logic [CFG_BITS-1:0]   max_reg, max_next;
    logic [FUNC_BITS-1:0]  func_reg, func_next;
    logic [MS_BITS-1:0]    ms_reg, ms_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic [TIMER_BITS-1:0] interval_reg, interval_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                  rising_reg, rising_next;
    logic [TIMER_BITS-1:0] quo_reg, quo_next;
    logic [CFG_BITS-1:0]   rem_reg, rem_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [OUT_BITS-1:0]   out_reg, out_next;

    logic [LEVEL_BITS-1:0] top;
    logic [CFG_BITS-1:0]   divisor;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic                  fade_end;
    logic [CFG_BITS:0]     trial;
    logic                  trial_ge;
    logic [TIMER_BITS-1:0] quo_shift;

    // Full-on level is the register masked to the level width.
    assign top     = LEVEL_BITS'(max_reg);
    assign divisor = CFG_BITS'(top);

    assign elapsed_inc = (elapsed_reg < TIMER_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign fade_end    = (!rising_reg && (level_reg == '0)) ||
                         (rising_reg && (level_reg >= top));

    // Restoring divider: shift one dividend bit into the remainder per step.
    assign trial     = {rem_reg, quo_reg[TIMER_BITS-1]};
    assign trial_ge  = (trial >= {1'b0, divisor});
    assign quo_shift = {quo_reg[TIMER_BITS-2:0], trial_ge};

    assign status.func     = func_reg;
    assign status.top_zero = (top == '0);
    assign status.div_last = (cnt_reg == DIV_LAST);

    assign m_tdata = out_reg;

    always_comb begin
        max_next      = cfg_we ? cfg_wdata : max_reg;
        func_next     = func_reg;
        ms_next       = ms_reg;
        level_next    = level_reg;
        interval_next = interval_reg;
        elapsed_next  = elapsed_reg;
        rising_next   = rising_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        out_next      = out_reg;

        if (cmd.capture) begin
            func_next = s_func;
            ms_next   = s_fade_ms;
        end

        if (cmd.do_tick) begin
            elapsed_next = elapsed_inc;
            if ((interval_reg != '0) && (elapsed_inc >= interval_reg)) begin
                if (fade_end) begin
                    interval_next = '0;
                end else begin
                    level_next   = rising_reg ? level_reg + LEVEL_BITS'(1)
                                              : level_reg - LEVEL_BITS'(1);
                    elapsed_next = '0;
                end
            end
        end

        if (cmd.do_off) begin
            level_next    = '0;
            interval_next = '0;
        end

        if (cmd.do_on) begin
            level_next    = top;
            interval_next = '0;
        end

        if (cmd.fade_start) begin
            elapsed_next = '0;
            rising_next  = (func_reg == FUNC_SOFT_ON);
            quo_next     = TIMER_BITS'(ms_reg) * TIMER_BITS'(US_PER_MS);
            rem_next     = '0;
            cnt_next     = '0;
            if (top == '0) begin
                interval_next = '0;
            end
        end

        if (cmd.div_step) begin
            rem_next = trial_ge ? CFG_BITS'(trial - {1'b0, divisor}) : trial[CFG_BITS-1:0];
            quo_next = quo_shift;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST) begin
                interval_next = quo_shift;
            end
        end

        if (cmd.load_out) begin
            out_next = OUT_BITS'({interval_reg != '0, CFG_BITS'(level_reg)});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg      <= MAX_RESET;
            level_reg    <= '0;
            interval_reg <= '0;
            elapsed_reg  <= '0;
            rising_reg   <= 1'b0;
        end else begin
            max_reg      <= max_next;
            level_reg    <= level_next;
            interval_reg <= interval_next;
            elapsed_reg  <= elapsed_next;
            rising_reg   <= rising_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        ms_reg   <= ms_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

endmodule

>>> rtl/lbf_chk.sv
// Port-level checker for the fade ramp, bound to the top level.
module lbf_chk import lbf_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_BITS-1:0]  m_tdata
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk)
        aresetn && m_tvalid && !m_tready |=> !aresetn || (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One command in flight: ready drops right after an accepted transaction.
    a_one_item: assert property (@(posedge aclk)
        aresetn && s_tvalid && s_tready |=> !s_tready)
        else $error("second command accepted back to back");

    a_pad_zero: assert property (@(posedge aclk)
        m_tvalid |-> (m_tdata[OUT_BITS-1:9] == '0))
        else $error("result padding bits not zero");

endmodule

bind led_brightness_fade_ramp lbf_chk u_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
